FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the frame transform block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every clock edge outside reset.
`define RMFT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define RMFT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RMFT_ASSERT(lbl, prop, msg)
`define RMFT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/rmft_pkg.sv
// ----------------------------------------------------------------------------
// Frame transform package
// Word types, fixed-point widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmft_pkg;

    localparam int XW = 36;
    localparam int ZW = 34;
    localparam int PW = XW + 32;

    localparam logic [31:0] INV_GAIN = 32'd652032874;

    localparam logic [2:0] REG_MOUNT_X_0     = 3'd0;
    localparam logic [2:0] REG_MOUNT_X_1     = 3'd1;
    localparam logic [2:0] REG_MOUNT_Y_0     = 3'd2;
    localparam logic [2:0] REG_MOUNT_Y_1     = 3'd3;
    localparam logic [2:0] REG_MOUNT_ANGLE_0 = 3'd4;
    localparam logic [2:0] REG_MOUNT_ANGLE_1 = 3'd5;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic        scanner_sel;
        logic [15:0] mark_distance_mm;
        logic [15:0] mark_angle_raw;
    } t_in_word;

    typedef struct packed {
        logic        [15:0] sensor_distance_mm;
        logic signed [15:0] sensor_angle;
        logic        [16:0] platform_distance_mm;
        logic signed [15:0] platform_angle;
    } t_out_word;

    typedef struct packed {
        logic        [15:0] d;
        logic signed [15:0] s_ang;
        logic               flip;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic               base;
        logic               origin;
    } t_side;

endpackage

FILE: sv/rmft_cordic_stage.sv
// ----------------------------------------------------------------------------
// CORDIC stage
// One registered micro-rotation, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmft_cordic_stage
    import rmft_pkg::*;
#(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output t_side                o_side
);

    localparam int SH = STEP % 32;
    localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[SH]);

    logic                 r_valid;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    t_side                r_side;
    logic                 pos;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    always_comb begin
        xs  = i_x >>> SH;
        ys  = i_y >>> SH;
        pos = VECTOR ? !i_y[XW-1] : !i_z[ZW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_side <= i_side;
            if (pos != VECTOR) begin
                r_x <= i_x - ys;
                r_y <= i_y + xs;
                r_z <= i_z - ANG;
            end else begin
                r_x <= i_x + ys;
                r_y <= i_y - xs;
                r_z <= i_z + ANG;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

FILE: sv/reflector_mark_frame_transform.sv
// ----------------------------------------------------------------------------
// Reflector mark frame transform
// Converts a scanner mark into sensor-frame and platform-frame polar words.
// ----------------------------------------------------------------------------
// A word accepted at the input is registered in P1 to P5, the rotation chain,
// U1, U2, V0, the vectoring chain, F1 to F4 and the output register, in order.
// Throughput: one word per cycle unless the output stalls; every stage,
// including both CORDIC chains, is a register stage that loads when enabled.
// A one-word skid buffer takes one more word after the output stalls.
// Synchronous active-low reset clears all valid bits and loads mount defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module reflector_mark_frame_transform
    import rmft_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [15:0] r_mount_x [2];
    logic signed [15:0] r_mount_y [2];
    logic        [15:0] r_mount_a [2];
    logic [2:0]         reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mount_x[0] <= 16'sd336;
            r_mount_x[1] <= -16'sd336;
            r_mount_y[0] <= 16'sd0;
            r_mount_y[1] <= 16'sd0;
            r_mount_a[0] <= 16'd0;
            r_mount_a[1] <= 16'd21600;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_MOUNT_X_0:     r_mount_x[0] <= pwdata[15:0];
                REG_MOUNT_X_1:     r_mount_x[1] <= pwdata[15:0];
                REG_MOUNT_Y_0:     r_mount_y[0] <= pwdata[15:0];
                REG_MOUNT_Y_1:     r_mount_y[1] <= pwdata[15:0];
                REG_MOUNT_ANGLE_0: r_mount_a[0] <= pwdata[15:0];
                REG_MOUNT_ANGLE_1: r_mount_a[1] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MOUNT_X_0:     prdata = {16'd0, r_mount_x[0]};
            REG_MOUNT_X_1:     prdata = {16'd0, r_mount_x[1]};
            REG_MOUNT_Y_0:     prdata = {16'd0, r_mount_y[0]};
            REG_MOUNT_Y_1:     prdata = {16'd0, r_mount_y[1]};
            REG_MOUNT_ANGLE_0: prdata = {16'd0, r_mount_a[0]};
            REG_MOUNT_ANGLE_1: prdata = {16'd0, r_mount_a[1]};
            default:           prdata = 32'd0;
        endcase
    end

    // Input skid buffer and global pipeline advance.
    logic     en;
    logic     acc_in;
    logic     r_skid_valid;
    t_in_word r_skid;
    t_in_word src;
    logic     src_valid;

    logic r_out_valid;

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_skid_valid;
    assign acc_in     = i_in_valid && !r_skid_valid;
    assign src        = r_skid_valid ? r_skid : i_in_word;
    assign src_valid  = r_skid_valid || acc_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (en) begin
            r_skid_valid <= r_skid_valid && acc_in;
        end else if (acc_in) begin
            r_skid_valid <= 1'b1;
        end
        if ((en && r_skid_valid) || (!en && acc_in)) begin
            r_skid <= i_in_word;
        end
    end

    // P1: reduce raw and mounting angles below a full turn.
    logic               r1_valid;
    logic [15:0]        r1_d;
    logic [15:0]        r1_a;
    logic [15:0]        r1_ma;
    logic signed [15:0] r1_mx;
    logic signed [15:0] r1_my;
    logic [15:0]        ma_sel;

    assign ma_sel = r_mount_a[src.scanner_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= src_valid;
        end
        if (en) begin
            r1_d  <= src.mark_distance_mm;
            r1_a  <= (src.mark_angle_raw >= 16'd43200) ? src.mark_angle_raw - 16'd43200
                                                       : src.mark_angle_raw;
            r1_ma <= (ma_sel >= 16'd43200) ? ma_sel - 16'd43200 : ma_sel;
            r1_mx <= r_mount_x[src.scanner_sel];
            r1_my <= r_mount_y[src.scanner_sel];
        end
    end

    // P2: sensor angle and total rotation angle into (-180, 180].
    logic               r2_valid;
    logic [15:0]        r2_d;
    logic signed [15:0] r2_s;
    logic signed [16:0] r2_t;
    logic signed [15:0] r2_mx;
    logic signed [15:0] r2_my;
    logic [16:0]        sa;
    logic [16:0]        sa2;
    logic [16:0]        ts;
    logic [16:0]        ts2;

    always_comb begin
        sa  = 17'(r1_a) + 17'd32400;
        sa2 = (sa >= 17'd43200) ? sa - 17'd43200 : sa;
        ts  = 17'(r1_a) + 17'd32400 + 17'(r1_ma);
        if (ts >= 17'd86400) begin
            ts2 = ts - 17'd86400;
        end else if (ts >= 17'd43200) begin
            ts2 = ts - 17'd43200;
        end else begin
            ts2 = ts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
        if (en) begin
            r2_d  <= r1_d;
            r2_s  <= (sa2 > 17'd21600) ? 16'(sa2 - 17'd43200) : 16'(sa2);
            r2_t  <= (ts2 > 17'd21600) ? ts2 - 17'd43200 : ts2;
            r2_mx <= r1_mx;
            r2_my <= r1_my;
        end
    end

    // P3: fold into a half turn and start the conversion to a binary angle.
    t_side              side3;
    logic               r3_valid;
    t_side              r3_side;
    logic               r3_neg;
    logic [30:0]        r3_zhi;
    logic [21:0]        r3_v;
    logic signed [16:0] tf;
    logic               fold;
    logic [16:0]        tmag;
    logic [13:0]        m;

    always_comb begin
        fold = 1'b1;
        if (r2_t > 17'sd10800) begin
            tf = r2_t - 17'sd21600;
        end else if (r2_t < -17'sd10800) begin
            tf = r2_t + 17'sd21600;
        end else begin
            tf   = r2_t;
            fold = 1'b0;
        end
        tmag          = tf[16] ? 17'(-tf) : 17'(tf);
        m             = tmag[13:0];
        side3         = '0;
        side3.d       = r2_d;
        side3.s_ang   = r2_s;
        side3.flip    = fold;
        side3.mx      = r2_mx;
        side3.my      = r2_my;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
        if (en) begin
            r3_side <= side3;
            r3_neg  <= tf[16];
            r3_zhi  <= 31'(m) * 31'd99420;
            r3_v    <= 22'(m) * 22'd364 + 22'd337;
        end
    end

    // P4: quotient of the division by 675 through a reciprocal product.
    logic        r4_valid;
    t_side       r4_side;
    logic        r4_neg;
    logic [30:0] r4_zhi;
    logic [44:0] r4_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
        if (en) begin
            r4_side <= r3_side;
            r4_neg  <= r3_neg;
            r4_zhi  <= r3_zhi;
            r4_prod <= 45'(r3_v) * 45'd6362915;
        end
    end

    // P5: binary angle and initial vector.
    logic                 r5_valid;
    t_side                r5_side;
    logic signed [ZW-1:0] r5_z;
    logic [30:0]          zmag;

    assign zmag = r4_zhi + 31'(r4_prod[44:32]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= r4_valid;
        end
        if (en) begin
            r5_side <= r4_side;
            r5_z    <= r4_neg ? -ZW'(zmag) : ZW'(zmag);
        end
    end

    // Rotation chain.
    logic                 rot_v [CORDIC_STEPS+1];
    logic signed [XW-1:0] rot_x [CORDIC_STEPS+1];
    logic signed [XW-1:0] rot_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] rot_z [CORDIC_STEPS+1];
    t_side                rot_s [CORDIC_STEPS+1];

    assign rot_v[0] = r5_valid;
    assign rot_x[0] = XW'({r5_side.d, 12'd0});
    assign rot_y[0] = '0;
    assign rot_z[0] = r5_z;
    assign rot_s[0] = r5_side;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
        rmft_cordic_stage #(
            .STEP   (g),
            .VECTOR (1'b0)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (rot_v[g]),
            .i_x     (rot_x[g]),
            .i_y     (rot_y[g]),
            .i_z     (rot_z[g]),
            .i_side  (rot_s[g]),
            .o_valid (rot_v[g+1]),
            .o_x     (rot_x[g+1]),
            .o_y     (rot_y[g+1]),
            .o_z     (rot_z[g+1]),
            .o_side  (rot_s[g+1])
        );
    end

    // U1: gain correction products.
    logic                 ru1_valid;
    t_side                ru1_side;
    logic signed [PW-1:0] ru1_px;
    logic signed [PW-1:0] ru1_py;
    logic signed [PW-1:0] gain_w;

    assign gain_w = PW'(signed'({1'b0, INV_GAIN}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ru1_valid <= 1'b0;
        end else if (en) begin
            ru1_valid <= rot_v[CORDIC_STEPS];
        end
        if (en) begin
            ru1_side <= rot_s[CORDIC_STEPS];
            ru1_px   <= PW'(rot_x[CORDIC_STEPS]) * gain_w;
            ru1_py   <= PW'(rot_y[CORDIC_STEPS]) * gain_w;
        end
    end

    // U2: round, undo the fold and add the mounting offset.
    logic                 ru2_valid;
    t_side                ru2_side;
    logic signed [XW-1:0] ru2_x;
    logic signed [XW-1:0] ru2_y;
    logic signed [XW-1:0] ux;
    logic signed [XW-1:0] uy;
    logic signed [PW-1:0] half30;

    assign half30 = PW'(64'sd536870912);
    assign ux     = XW'((ru1_px + half30) >>> 30);
    assign uy     = XW'((ru1_py + half30) >>> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ru2_valid <= 1'b0;
        end else if (en) begin
            ru2_valid <= ru1_valid;
        end
        if (en) begin
            ru2_side <= ru1_side;
            ru2_x    <= (ru1_side.flip ? -ux : ux) + (XW'(ru1_side.mx) <<< 12);
            ru2_y    <= (ru1_side.flip ? -uy : uy) + (XW'(ru1_side.my) <<< 12);
        end
    end

    // V0: move the point into the right half plane.
    logic                 rv0_valid;
    t_side                rv0_side;
    logic signed [XW-1:0] rv0_x;
    logic signed [XW-1:0] rv0_y;
    t_side                side_v;

    always_comb begin
        side_v        = ru2_side;
        side_v.origin = (ru2_x == '0) && (ru2_y == '0);
        side_v.base   = ru2_x[XW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rv0_valid <= 1'b0;
        end else if (en) begin
            rv0_valid <= ru2_valid;
        end
        if (en) begin
            rv0_side <= side_v;
            rv0_x    <= ru2_x[XW-1] ? -ru2_x : ru2_x;
            rv0_y    <= ru2_x[XW-1] ? -ru2_y : ru2_y;
        end
    end

    // Vectoring chain.
    logic                 vec_v [CORDIC_STEPS+1];
    logic signed [XW-1:0] vec_x [CORDIC_STEPS+1];
    logic signed [XW-1:0] vec_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] vec_z [CORDIC_STEPS+1];
    t_side                vec_s [CORDIC_STEPS+1];

    assign vec_v[0] = rv0_valid;
    assign vec_x[0] = rv0_x;
    assign vec_y[0] = rv0_y;
    assign vec_z[0] = '0;
    assign vec_s[0] = rv0_side;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
        rmft_cordic_stage #(
            .STEP   (g),
            .VECTOR (1'b1)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (vec_v[g]),
            .i_x     (vec_x[g]),
            .i_y     (vec_y[g]),
            .i_z     (vec_z[g]),
            .i_side  (vec_s[g]),
            .o_valid (vec_v[g+1]),
            .o_x     (vec_x[g+1]),
            .o_y     (vec_y[g+1]),
            .o_z     (vec_z[g+1]),
            .o_side  (vec_s[g+1])
        );
    end

    // F1: add the half turn and wrap to a signed 32-bit turn.
    logic                 rf1_valid;
    t_side                rf1_side;
    logic signed [XW-1:0] rf1_x;
    logic [31:0]          rf1_zw;
    logic [ZW-1:0]        zsum;

    assign zsum = ZW'(vec_z[CORDIC_STEPS]) + ZW'({vec_s[CORDIC_STEPS].base, 31'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf1_valid <= 1'b0;
        end else if (en) begin
            rf1_valid <= vec_v[CORDIC_STEPS];
        end
        if (en) begin
            rf1_side <= vec_s[CORDIC_STEPS];
            rf1_x    <= vec_x[CORDIC_STEPS];
            rf1_zw   <= zsum[31:0];
        end
    end

    // F2: angle magnitude and magnitude gain product.
    logic                 rf2_valid;
    t_side                rf2_side;
    logic                 rf2_neg;
    logic [31:0]          rf2_mag;
    logic signed [PW-1:0] rf2_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf2_valid <= 1'b0;
        end else if (en) begin
            rf2_valid <= rf1_valid;
        end
        if (en) begin
            rf2_side <= rf1_side;
            rf2_neg  <= rf1_zw[31];
            rf2_mag  <= rf1_zw[31] ? 32'(-rf1_zw) : rf1_zw;
            rf2_px   <= PW'(rf1_x) * gain_w;
        end
    end

    // F3: conversion product and rounded magnitude.
    logic                 rf3_valid;
    t_side                rf3_side;
    logic                 rf3_neg;
    logic [47:0]          rf3_prod;
    logic signed [XW-1:0] rf3_ug;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf3_valid <= 1'b0;
        end else if (en) begin
            rf3_valid <= rf2_valid;
        end
        if (en) begin
            rf3_side <= rf2_side;
            rf3_neg  <= rf2_neg;
            rf3_prod <= 48'(rf2_mag) * 48'd43200;
            rf3_ug   <= XW'((rf2_px + half30) >>> 30);
        end
    end

    // F4: final angle and distance.
    logic                 rf4_valid;
    t_out_word            rf4_word;
    logic [47:0]          usum;
    logic [15:0]          uabs;
    logic signed [XW-1:0] pdw;
    t_out_word            word4;

    always_comb begin
        usum  = rf3_prod + 48'h0000_8000_0000;
        uabs  = usum[47:32];
        pdw   = (rf3_ug + XW'(2048)) >>> 12;
        word4 = '0;
        word4.sensor_distance_mm = rf3_side.d;
        word4.sensor_angle       = rf3_side.s_ang;
        if (rf3_side.origin) begin
            word4.platform_distance_mm = 17'd0;
            word4.platform_angle       = 16'sd0;
        end else begin
            if (pdw[XW-1]) begin
                word4.platform_distance_mm = 17'd0;
            end else if (pdw > XW'(131071)) begin
                word4.platform_distance_mm = 17'd131071;
            end else begin
                word4.platform_distance_mm = pdw[16:0];
            end
            word4.platform_angle = (rf3_neg && uabs != 16'd21600) ? -uabs : uabs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf4_valid <= 1'b0;
        end else if (en) begin
            rf4_valid <= rf3_valid;
        end
        if (en) begin
            rf4_word <= word4;
        end
    end

    // Output register.
    t_out_word r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= rf4_valid;
        end
        if (en) begin
            r_out_word <= rf4_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `RMFT_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !r_out_valid && !r_skid_valid, "valid after reset")
    `RMFT_ASSERT(a_skid_only_on_stall, $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall), "skid filled without stall")
    `RMFT_ASSERT(a_sensor_range, r_out_valid |-> (r_out_word.sensor_angle > -16'sd21600 && r_out_word.sensor_angle <= 16'sd21600), "sensor angle out of range")
    `RMFT_ASSERT(a_platform_range, r_out_valid |-> (r_out_word.platform_angle > -16'sd21600 && r_out_word.platform_angle <= 16'sd21600), "platform angle out of range")

endmodule
